@@ rtl/ibl_pkg.sv @@
// shared types and codes for the indexed byte list
`timescale 1ns / 1ps

package ibl_pkg;

    typedef enum logic [2:0] {
        OP_SET    = 3'd0,
        OP_GET    = 3'd1,
        OP_APPEND = 3'd2,
        OP_INSERT = 3'd3,
        OP_DELETE = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // per-request control broadcast along the cell row
    typedef struct packed {
        logic       set_en;
        logic       insert_en;
        logic       delete_en;
        logic [7:0] value;
    } ctrl_t;

endpackage

@@ rtl/indexed_byte_list_insert_delete_unit.sv @@
// top level of the indexed byte list: status logic, cell row and result register
// Append, insert and delete move the cells at and above the target place by one in the
// cycle the request is accepted; set, get, append, insert and delete run at one request
// per cycle while the result is not stalled. The result is held in an output register and
// a new request is taken unless that result is stalled. The list holds up to CAPACITY
// bytes; append and insert report list full beyond that. Indices are 8 bits wide, so
// with CAPACITY above 256 the upper places are reached only by append and insert shifts.
`timescale 1ns / 1ps

module indexed_byte_list_insert_delete_unit #(
    parameter int CAPACITY = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        func,
    input  logic [7:0]                        index,
    input  logic [7:0]                        value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [7:0]                        read_value,
    output logic [$clog2(CAPACITY+1)-1:0]     count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                out_valid_reg;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic [7:0]          read_value_reg;
    logic [7:0]          read_value_next;
    logic [CW-1:0]       count_out_reg;

    logic                accept;
    logic [PW-1:0]       idx_w;
    logic [PW-1:0]       cnt_w;
    logic [PW-1:0]       pos_w;
    logic                full;
    logic                get_ok;
    logic                append_ok;
    ibl_pkg::ctrl_t      ctrl;
    logic [7:0]          rd_any;

    logic [7:0]          cell_data [CAPACITY];
    logic [7:0]          cell_rd   [CAPACITY];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign idx_w = PW'(index);
    assign cnt_w = PW'(count_reg);
    assign full  = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        status_next    = ibl_pkg::ST_OK;
        count_next     = count_reg;
        get_ok         = 1'b0;
        append_ok      = 1'b0;
        ctrl.set_en    = 1'b0;
        ctrl.insert_en = 1'b0;
        ctrl.delete_en = 1'b0;
        ctrl.value     = value;
        case (func)
            ibl_pkg::OP_SET:
            begin
                if (idx_w < cnt_w)
                begin
                    ctrl.set_en = accept;
                end
                else
                begin
                    status_next = ibl_pkg::ST_RANGE;
                end
            end
            ibl_pkg::OP_GET:
            begin
                if (idx_w < cnt_w)
                begin
                    get_ok = 1'b1;
                end
                else
                begin
                    status_next = ibl_pkg::ST_RANGE;
                end
            end
            ibl_pkg::OP_APPEND:
            begin
                if (full)
                begin
                    status_next = ibl_pkg::ST_FULL;
                end
                else
                begin
                    append_ok      = 1'b1;
                    ctrl.insert_en = accept;
                    count_next     = count_reg + CW'(1);
                end
            end
            ibl_pkg::OP_INSERT:
            begin
                if (idx_w > cnt_w)
                begin
                    status_next = ibl_pkg::ST_RANGE;
                end
                else if (full)
                begin
                    status_next = ibl_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.insert_en = accept;
                    count_next     = count_reg + CW'(1);
                end
            end
            ibl_pkg::OP_DELETE:
            begin
                if (count_reg == '0)
                begin
                    status_next = ibl_pkg::ST_EMPTY;
                end
                else if (idx_w >= cnt_w)
                begin
                    status_next = ibl_pkg::ST_RANGE;
                end
                else
                begin
                    ctrl.delete_en = accept;
                    count_next     = count_reg - CW'(1);
                end
            end
            default:
            begin
                status_next = ibl_pkg::ST_RANGE;
            end
        endcase
    end

    // append is an insert at the end of the list
    assign pos_w = append_ok ? cnt_w : idx_w;

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            logic [7:0] left_in;
            logic [7:0] right_in;
            if (k == 0)
            begin : g_first
                assign left_in = value;
            end
            else
            begin : g_mid_l
                assign left_in = cell_data[k-1];
            end
            if (k == CAPACITY - 1)
            begin : g_last
                assign right_in = cell_data[k];
            end
            else
            begin : g_mid_r
                assign right_in = cell_data[k+1];
            end
            ibl_cell #(
                .IDX (k),
                .PW  (PW)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .pos        (pos_w),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[k]),
                .rd_data    (cell_rd[k])
            );
        end
    endgenerate

    // at most one cell drives a non-zero read byte
    always_comb
    begin
        rd_any = 8'd0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    assign read_value_next = get_ok ? rd_any : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            count_out_reg  <= count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign count      = count_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == ibl_pkg::OP_APPEND && !full)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("append did not grow the list");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg && count_out_reg == count_reg)
        else $error("result missing or count mismatch after request");

    a_read_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ibl_pkg::ST_OK) |-> read_value_reg == 8'd0)
        else $error("read byte set on failed request");

endmodule

@@ rtl/ibl_cell.sv @@
// one storage cell of the list row, with shift links to both neighbours
`timescale 1ns / 1ps

module ibl_cell #(
    parameter int IDX = 0,
    parameter int PW  = 9
) (
    input  logic            clk,
    input  ibl_pkg::ctrl_t  ctrl,
    input  logic [PW-1:0]   pos,
    input  logic [7:0]      left_data,
    input  logic [7:0]      right_data,
    output logic [7:0]      data,
    output logic [7:0]      rd_data
);

    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       at_pos;
    logic       above;

    assign at_pos = (pos == PW'(IDX));
    assign above  = (PW'(IDX) > pos);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.insert_en && at_pos)
        begin
            data_next = ctrl.value;
        end
        else if (ctrl.insert_en && above)
        begin
            data_next = left_data;
        end
        else if (ctrl.set_en && at_pos)
        begin
            data_next = ctrl.value;
        end
        else if (ctrl.delete_en && (at_pos || above))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = at_pos ? data_reg : 8'd0;

endmodule
